// ===== design/bitr_pkg.sv =====
// ----------------------------------------------------------------------------
// bitr_pkg
// Shared types, widths and codes of the bone id table resolver.
// ----------------------------------------------------------------------------
package bitr_pkg;

  localparam int TABLE_DEPTH_DEF = 1024;

  localparam int ID_W     = 32;
  localparam int LIMIT_W  = 32;
  localparam int ESLOT_W  = 10;
  localparam int FLAGS_W  = 8;
  localparam int TSIZE_W  = 11;
  localparam int OSLOT_W  = 11;
  localparam int STAT_W   = 3;
  localparam int ADDR_W   = 4;
  localparam int DATA_W   = 32;
  localparam int S_DATA_W = 128;
  localparam int M_DATA_W = 24;

  localparam logic [FLAGS_W-1:0] FLAG_MASK_RST = 8'h10;
  localparam logic [OSLOT_W-1:0] SLOT_NONE     = 11'h7FF;

  // status codes
  localparam logic [STAT_W-1:0] ST_MASKED = 3'd0;
  localparam logic [STAT_W-1:0] ST_ROOT   = 3'd1;
  localparam logic [STAT_W-1:0] ST_MATCH  = 3'd2;
  localparam logic [STAT_W-1:0] ST_FAR    = 3'd3;
  localparam logic [STAT_W-1:0] ST_NONE   = 3'd4;

  // register indexes
  localparam logic [1:0] REG_ROOT_ID  = 2'd0;
  localparam logic [1:0] REG_FLAGMASK = 2'd1;
  localparam logic [1:0] REG_TSIZE    = 2'd2;
  localparam logic [1:0] REG_LOD      = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]    root_id;
    logic [FLAGS_W-1:0] flag_mask;
    logic [TSIZE_W-1:0] table_size;
    logic [LIMIT_W-1:0] lod_distance;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic start;
    logic rd;
    logic cmp;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic early;
    logic hit;
    logic last;
    logic out_busy;
  } sts_t;

endpackage

// ===== design/bitr_cfg.sv =====
// ----------------------------------------------------------------------------
// bitr_cfg
// APB register file: root id, flag mask, table size, distance.
// ----------------------------------------------------------------------------
module bitr_cfg
  import bitr_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg_o
);

  cfg_t cfg_q;
  logic wr;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.root_id      <= '0;
      cfg_q.flag_mask    <= FLAG_MASK_RST;
      cfg_q.table_size   <= TSIZE_W'(1);
      cfg_q.lod_distance <= '0;
    end else if (wr) begin
      unique case (paddr[3:2])
        REG_ROOT_ID:  cfg_q.root_id      <= pwdata[ID_W-1:0];
        REG_FLAGMASK: cfg_q.flag_mask    <= pwdata[FLAGS_W-1:0];
        REG_TSIZE:    cfg_q.table_size   <= pwdata[TSIZE_W-1:0];
        REG_LOD:      cfg_q.lod_distance <= pwdata[LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_ROOT_ID:  prdata = cfg_q.root_id;
      REG_FLAGMASK: prdata = DATA_W'(cfg_q.flag_mask);
      REG_TSIZE:    prdata = DATA_W'(cfg_q.table_size);
      REG_LOD:      prdata = cfg_q.lod_distance;
      default:      prdata = '0;
    endcase
  end

endmodule

// ===== design/bitr_ctrl.sv =====
// ----------------------------------------------------------------------------
// bitr_ctrl
// Sequencer: accepts requests, steps the table search, hands off results.
// ----------------------------------------------------------------------------
module bitr_ctrl
  import bitr_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  input  logic in_req_type_i,
  output logic in_ready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_RD,
    S_CMP,
    S_DONE
  } state_e;

  state_e state_q, state_d;
  logic   acc;

  assign in_ready_o = (state_q == S_IDLE);
  assign acc        = in_valid_i & in_ready_o;

  always_comb begin
    cmd_o       = '0;
    cmd_o.load  = acc & ~in_req_type_i;
    cmd_o.start = acc & in_req_type_i;
    cmd_o.rd    = (state_q == S_RD);
    cmd_o.cmp   = (state_q == S_CMP);
    cmd_o.emit  = (state_q == S_DONE) & ~sts_i.out_busy;
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (cmd_o.start) state_d = sts_i.early ? S_DONE : S_RD;
      S_RD:   state_d = S_CMP;
      S_CMP:  state_d = (sts_i.hit | sts_i.last) ? S_DONE : S_RD;
      S_DONE: if (!sts_i.out_busy) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

// ===== design/bitr_dp.sv =====
// ----------------------------------------------------------------------------
// bitr_dp
// Datapath: entry table memory, search position, compare and result register.
// ----------------------------------------------------------------------------
module bitr_dp
  import bitr_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  cfg_t                cfg_i,
  input  cmd_t                cmd_i,
  output sts_t                sts_o,
  input  logic [ESLOT_W-1:0]  entry_slot_i,
  input  logic [ID_W-1:0]     entry_id_i,
  input  logic [LIMIT_W-1:0]  entry_limit_i,
  input  logic [ESLOT_W-1:0]  entry_out_slot_i,
  input  logic [ID_W-1:0]     bone_id_i,
  input  logic [FLAGS_W-1:0]  path_flags_i,
  input  logic                restart_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [M_DATA_W-1:0] out_data_o
);

  localparam int IW   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int SZ_W = $clog2(TABLE_DEPTH + 1);
  localparam int NW   = SZ_W + 1;
  localparam int CW   = (NW > TSIZE_W) ? NW : TSIZE_W;

  typedef struct packed {
    logic [ID_W-1:0]    id;
    logic [LIMIT_W-1:0] limit;
    logic [ESLOT_W-1:0] slot;
  } entry_t;

  entry_t mem [TABLE_DEPTH];
  entry_t rdata_q;

  logic [IW-1:0]      pos_q, cur_q, cur_nxt, start_pos;
  logic [SZ_W-1:0]    cnt_q, size_q, size_use;
  logic [ID_W-1:0]    id_q;
  logic [FLAGS_W-1:0] flags_q;
  logic [OSLOT_W-1:0] res_slot_q;
  logic [STAT_W-1:0]  res_stat_q;
  logic               out_valid_q;
  logic [M_DATA_W-1:0] out_data_q;

  logic [CW-1:0] ts_ext;
  logic [NW-1:0] cur_inc, cnt_inc, pos_base;
  logic          masked, root, wr_ok;

  // size in use, clamped to 1..TABLE_DEPTH
  assign ts_ext = CW'(cfg_i.table_size);
  always_comb begin
    if (ts_ext == '0)                  size_use = SZ_W'(1);
    else if (ts_ext > CW'(TABLE_DEPTH)) size_use = SZ_W'(TABLE_DEPTH);
    else                               size_use = SZ_W'(ts_ext);
  end

  assign masked   = (path_flags_i & cfg_i.flag_mask) == '0;
  assign root     = (bone_id_i == cfg_i.root_id);
  assign wr_ok    = 32'(entry_slot_i) < 32'(TABLE_DEPTH);

  assign pos_base  = restart_i ? '0 : NW'(pos_q);
  assign start_pos = (pos_base >= NW'(size_use)) ? '0 : IW'(pos_base);

  assign cur_inc = NW'(cur_q) + NW'(1);
  assign cur_nxt = (cur_inc >= NW'(size_q)) ? '0 : IW'(cur_inc);
  assign cnt_inc = NW'(cnt_q) + NW'(1);

  assign sts_o.early    = masked | root;
  assign sts_o.hit      = (rdata_q.id == id_q);
  assign sts_o.last     = (cnt_inc == NW'(size_q));
  assign sts_o.out_busy = out_valid_q & ~out_ready_i;

  // table memory, one write port and one registered read port
  always_ff @(posedge clk_i) begin
    if (cmd_i.load && wr_ok) begin
      mem[IW'(entry_slot_i)] <= entry_t'({entry_id_i, entry_limit_i, entry_out_slot_i});
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[cur_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (cmd_i.start && restart_i) begin
      pos_q <= '0;
    end else if (cmd_i.cmp && (sts_o.hit || sts_o.last)) begin
      pos_q <= cur_nxt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      id_q    <= bone_id_i;
      flags_q <= path_flags_i;
      size_q  <= size_use;
      cur_q   <= start_pos;
      cnt_q   <= '0;
      if (masked) begin
        res_slot_q <= SLOT_NONE;
        res_stat_q <= ST_MASKED;
      end else begin
        res_slot_q <= '0;
        res_stat_q <= ST_ROOT;
      end
    end else if (cmd_i.cmp) begin
      cur_q <= cur_nxt;
      cnt_q <= SZ_W'(cnt_inc);
      if (sts_o.hit) begin
        if (cfg_i.lod_distance <= rdata_q.limit) begin
          res_slot_q <= OSLOT_W'(rdata_q.slot);
          res_stat_q <= ST_MATCH;
        end else begin
          res_slot_q <= SLOT_NONE;
          res_stat_q <= ST_FAR;
        end
      end else begin
        res_slot_q <= SLOT_NONE;
        res_stat_q <= ST_NONE;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q <= M_DATA_W'({res_stat_q, flags_q, res_slot_q});
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// ===== design/bone_id_table_resolver.sv =====
// ----------------------------------------------------------------------------
// bone_id_table_resolver
// Maps animation bone ids to output slots through a loaded skeleton table.
// ----------------------------------------------------------------------------
// A load transaction (tuser 0) writes one table entry; the input stays ready.
// A resolve transaction (tuser 1) yields one result: a masked-out or root
// bone goes from acceptance straight to the done state, and the input is
// ready again as the result enters the output register; any other bone
// searches the table from the saved position, each entry examined taking a
// read state and a compare state (address, then compare on the registered
// read of the table memory), and at most size entries are read before the
// search goes to the done state.
// A result moves into the output register only once it is free; a stalled
// sink adds its stall to the transaction. The table needs no clearing after
// reset; read an entry only once loaded.
// A finished result waits in the output register while the next request is
// taken. Registers: 0x0 root_id, 0x4 flag_mask, 0x8 table_size,
// 0xC lod_distance; write them only while the block is idle.
// ----------------------------------------------------------------------------
module bone_id_table_resolver
  import bitr_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
)
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // entry_slot, entry_id, entry_limit, entry_out_slot, bone_id,
  // path_flags, restart
  input  logic [S_DATA_W-1:0] s_axis_tdata_i,
  // req_type
  input  logic                s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // out_slot, flags_echo, status
  output logic [M_DATA_W-1:0] m_axis_tdata_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready
);

  cfg_t cfg;
  cmd_t cmd;
  sts_t sts;

  bitr_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bitr_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_req_type_i (s_axis_tuser_i),
    .in_ready_o    (s_axis_tready_o),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  bitr_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_i            (cfg),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .entry_slot_i     (s_axis_tdata_i[9:0]),
    .entry_id_i       (s_axis_tdata_i[41:10]),
    .entry_limit_i    (s_axis_tdata_i[73:42]),
    .entry_out_slot_i (s_axis_tdata_i[83:74]),
    .bone_id_i        (s_axis_tdata_i[115:84]),
    .path_flags_i     (s_axis_tdata_i[123:116]),
    .restart_i        (s_axis_tdata_i[124]),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .out_data_o       (m_axis_tdata_o)
  );

endmodule
